// ===== rtl/core/centered_scatter_matrix_accumulator_core_assert.svh =====
// Assertion macros shared by the scatter matrix accumulator RTL.
`ifndef CENTERED_SCATTER_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH
`define CENTERED_SCATTER_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CSMA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define CSMA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/csma_pkg.sv =====
// Shared widths, limits and the sum memory word of the scatter matrix accumulator.
`timescale 1ns / 1ps

package csma_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int VALUE_W = 16;
   localparam int DIFF_W  = VALUE_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = 48;
   localparam int ACC_W   = SUM_W + 1;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Request actions carried in req_tuser.
   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_MEAN   = 2'd1,
      ACT_SAMPLE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   // One triangle entry as kept in the sum memory.
   typedef struct packed {
      logic                    mark;
      logic signed [SUM_W-1:0] sum;
   } sum_word_type;

endpackage

// ===== rtl/core/centered_scatter_matrix_accumulator_core.sv =====
// Centered scatter matrix accumulator: packed lower triangle of (x - m)(x - m)^T sums.
//
// Requests carry an action in req_tuser and a component index and Q7.8 value in
// req_tdata. A sample component with index i is centered against the stored mean
// and then updates its triangle row through one shared 17x17 multiply-accumulate,
// one entry per cycle; no new request is taken until the row is issued. A readout
// emits q(q+1)/2 entries in column order, each via ST_RD_ISSUE and ST_RD_DATA and
// the single read port of the sum memory, and waits while the response side stalls;
// the last entry carries rsp_tlast. Sums are signed Q31.16 in 48 bits and clamp on
// overflow with a sticky flag in rsp_tuser. Clear empties the whole triangle.
// dim_in_use must be written through the csr channel only while the block is idle;
// the block does not enforce this. 0 acts as 1, values above MAX_DIM as MAX_DIM.
`timescale 1ns / 1ps

`include "centered_scatter_matrix_accumulator_core_assert.svh"

module centered_scatter_matrix_accumulator_core #(
   parameter int MAX_DIM = csma_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request: [2:0] index, [18:3] value, [23:19] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request: [1:0] action
   input  logic [1:0]  req_tuser,
   // response: [2:0] row, [5:3] col, [53:6] sum, [55:54] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // response: [0] saturated
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast,
   // dimension in use
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   import csma_pkg::*;

   localparam int TRI     = MAX_DIM * (MAX_DIM + 1) / 2;
   localparam int POS_W   = TRI > 1 ? $clog2(TRI) : 1;
   localparam int IDX_W   = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
   localparam int FIELD_W = 3;
   localparam int DIM_W   = 4;
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

   // Request fields
   action_type                req_action;
   logic [FIELD_W-1:0]        req_index;
   logic signed [VALUE_W-1:0] req_value;

   assign req_action = action_type'(req_tuser);
   assign req_index  = req_tdata[2:0];
   assign req_value  = $signed(req_tdata[18:3]);

   // Sequencer and output registers
   state_type               state_ff, state_in;
   logic [FIELD_W-1:0]      idx_ff, idx_in;
   logic [FIELD_W-1:0]      c_ff, c_in;
   logic [FIELD_W-1:0]      r_ff, r_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]      rsp_row_ff, rsp_row_in;
   logic [FIELD_W-1:0]      rsp_col_ff, rsp_col_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_sat_ff, rsp_sat_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Stores
   logic [DIM_W-1:0]          dim_ff, dim_in;
   logic signed [VALUE_W-1:0] mean_ff [MAX_DIM];
   logic signed [VALUE_W-1:0] mean_in [MAX_DIM];
   logic signed [DIFF_W-1:0]  buf_ff  [MAX_DIM];
   logic signed [DIFF_W-1:0]  buf_in  [MAX_DIM];
   logic signed [DIFF_W-1:0]  d_ff, d_in;
   logic [TRI-1:0]            live_ff, live_in;

   // Datapath links
   logic [DIM_W-1:0]  q_eff;
   logic              col_end;
   logic              slot_free;
   logic              mac_valid;
   logic              mac_wr_en;
   logic [POS_W-1:0]  mac_wr_pos;
   sum_word_type      mac_wr_word;
   sum_word_type      ram_rdata;

   // Clamp the dimension in use to 1..MAX_DIM
   always_comb begin
      if (dim_ff == '0) begin
         q_eff = DIM_W'(1);
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         q_eff = DIM_W'(MAX_DIM);
      end else begin
         q_eff = dim_ff;
      end
   end

   assign col_end   = {1'b0, r_ff} == q_eff - DIM_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      dim_in       = dim_ff;
      mean_in      = mean_ff;
      buf_in       = buf_ff;
      d_in         = d_ff;
      live_in      = live_ff;
      mac_valid    = 1'b0;

      if (csr_valid) begin
         dim_in = csr_data;
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Mark an entry live once the MAC has written it
      if (mac_wr_en) begin
         live_in[mac_wr_pos] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_action)
                  ACT_CLEAR: begin
                     live_in = '0;
                  end
                  ACT_MEAN: begin
                     if ({1'b0, req_index} < DIM_W'(MAX_DIM)) begin
                        mean_in[req_index[IDX_W-1:0]] = req_value;
                     end
                  end
                  ACT_SAMPLE: begin
                     if ({1'b0, req_index} < q_eff) begin
                        d_in = DIFF_W'(req_value) - DIFF_W'(mean_ff[req_index[IDX_W-1:0]]);
                        buf_in[req_index[IDX_W-1:0]] = d_in;
                        idx_in   = req_index;
                        c_in     = '0;
                        pos_in   = POS_W'(req_index);
                        state_in = ST_MAC;
                     end
                  end
                  ACT_READ: begin
                     c_in     = '0;
                     r_in     = '0;
                     pos_in   = '0;
                     state_in = ST_RD_ISSUE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MAC: begin
            // Issue one entry of the row to the shared MAC
            mac_valid = 1'b1;
            if (c_ff == idx_ff) begin
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + POS_W'(MAX_DIM - 1) - POS_W'(c_ff);
               c_in   = c_ff + FIELD_W'(1);
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            // Load the entry when the output slot frees, then advance
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = r_ff;
               rsp_col_in   = c_ff;
               rsp_sum_in   = live_ff[pos_ff] ? ram_rdata.sum : '0;
               rsp_sat_in   = live_ff[pos_ff] ? ram_rdata.mark : 1'b0;
               rsp_last_in  = col_end && ({1'b0, c_ff} == q_eff - DIM_W'(1));
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD_ISSUE;
                  if (col_end) begin
                     c_in   = c_ff + FIELD_W'(1);
                     r_in   = c_ff + FIELD_W'(1);
                     pos_in = pos_ff + POS_W'(MAX_DIM) - POS_W'(q_eff) + POS_W'(1);
                  end else begin
                     r_in   = r_ff + FIELD_W'(1);
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, counters and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         c_ff         <= c_in;
         r_ff         <= r_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_sum_ff   <= rsp_sum_in;
         rsp_sat_ff   <= rsp_sat_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Hold the register, the mean and the live bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= DIM_RESET;
         mean_ff <= '{default: '0};
         live_ff <= '0;
      end else begin
         dim_ff  <= dim_in;
         mean_ff <= mean_in;
         live_ff <= live_in;
      end
   end

   // Hold the centered buffer
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      d_ff   <= d_in;
   end

   csma_mac #(
      .POS_W (POS_W)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mac_valid),
      .in_pos   (pos_ff),
      .op_a     (d_ff),
      .op_b     (buf_ff[c_ff[IDX_W-1:0]]),
      .rd_word  (ram_rdata),
      .rd_live  (live_ff[mac_wr_pos]),
      .wr_en    (mac_wr_en),
      .wr_pos   (mac_wr_pos),
      .wr_word  (mac_wr_word)
   );

   csma_ram #(
      .WIDTH ($bits(sum_word_type)),
      .DEPTH (TRI)
   ) u_sums (
      .clock (clock),
      .we    (mac_wr_en),
      .waddr (mac_wr_pos),
      .wdata (mac_wr_word),
      .raddr (pos_ff),
      .rdata (ram_rdata)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_sum_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CSMA_ASSERT_NOW(a_last_on_diagonal, rsp_tvalid && rsp_tlast,
                    rsp_row_ff == rsp_col_ff, "last entry off the diagonal")
   `CSMA_ASSERT_NOW(a_no_writeback_in_readout, state_ff == ST_RD_ISSUE || state_ff == ST_RD_DATA,
                    !mac_wr_en, "sum write during readout")
   `CSMA_ASSERT_NOW(a_col_within_row, state_ff == ST_MAC,
                    c_ff <= idx_ff, "MAC column past its row")
   `CSMA_ASSERT_NEXT(a_clear_empties, req_tvalid && req_tready && req_action == ACT_CLEAR,
                     $countones(live_ff) == 0, "entries live after clear")

endmodule

// ===== rtl/core/csma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module csma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, read every cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/csma_mac.sv =====
// Shared multiply-accumulate unit: product stage, then saturating add and write-back.
`timescale 1ns / 1ps

module csma_mac #(
   parameter int POS_W = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [POS_W-1:0]                    in_pos,
   input  logic signed [csma_pkg::DIFF_W-1:0]  op_a,
   input  logic signed [csma_pkg::DIFF_W-1:0]  op_b,
   input  csma_pkg::sum_word_type              rd_word,
   input  logic                                rd_live,
   output logic                                wr_en,
   output logic [POS_W-1:0]                    wr_pos,
   output csma_pkg::sum_word_type              wr_word
);

   import csma_pkg::*;

   logic                     valid_ff, valid_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   sum_word_type             old_word;
   logic signed [ACC_W-1:0]  acc;
   logic                     ovf;

   // Form the product of the centered pair.
   always_comb begin
      valid_in = in_valid;
      pos_in   = in_pos;
      prod_in  = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      prod_ff <= prod_in;
   end

   // Add to the stored sum; an entry not written since clear counts as zero.
   always_comb begin
      old_word = rd_live ? rd_word : '0;
      acc      = ACC_W'(old_word.sum) + ACC_W'(prod_ff);
      ovf      = acc[ACC_W-1] != acc[ACC_W-2];
      wr_word.mark = old_word.mark | ovf;
      if (ovf) begin
         wr_word.sum = acc[ACC_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         wr_word.sum = acc[SUM_W-1:0];
      end
   end

   assign wr_en  = valid_ff;
   assign wr_pos = pos_ff;

endmodule
